// ===== rtl/mbl_pkg.sv =====
// Shared types and constants of the multichannel biquad low-pass filter.
// Depends on nothing; every other file uses it through scoped names.
`timescale 1ns / 1ps

package mbl_pkg;

   // Number of channels that filter, and the fixed number of sample slots in a word.
   localparam int CHANNELS = 9;
   localparam int LANES    = 9;

   // Widths of samples, tap sum and exact accumulator, and the coefficient fraction bits.
   localparam int SAMPLE_W = 32;
   localparam int SUM_W    = SAMPLE_W + 2;
   localparam int ACC_W    = 67;
   localparam int FRAC_W   = 30;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_B      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_A1 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_A2 = 2'd2;

   // Coefficient values after reset, Q2.30.
   localparam logic signed [31:0] RESET_GAIN_B      = 32'sd1569273;
   localparam logic signed [31:0] RESET_FEEDBACK_A1 = -32'sd2028330518;
   localparam logic signed [31:0] RESET_FEEDBACK_A2 = 32'sd960865788;

   typedef struct packed {
      logic signed [31:0] gain_b;
      logic signed [31:0] feedback_a1;
      logic signed [31:0] feedback_a2;
   } coef_type;

   typedef struct packed {
      logic signed [31:0] sample_0;
      logic signed [31:0] sample_1;
      logic signed [31:0] sample_2;
      logic signed [31:0] sample_3;
      logic signed [31:0] sample_4;
      logic signed [31:0] sample_5;
      logic signed [31:0] sample_6;
      logic signed [31:0] sample_7;
      logic signed [31:0] sample_8;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] filtered_0;
      logic signed [31:0] filtered_1;
      logic signed [31:0] filtered_2;
      logic signed [31:0] filtered_3;
      logic signed [31:0] filtered_4;
      logic signed [31:0] filtered_5;
      logic signed [31:0] filtered_6;
      logic signed [31:0] filtered_7;
      logic signed [31:0] filtered_8;
   } rsp_word_type;

endpackage

// ===== rtl/mbl_coef.sv =====
// Coefficient register file of the biquad filter, written through the plain write port.
// Depends on mbl_pkg for the register indexes, reset values and coef_type.
`timescale 1ns / 1ps

module mbl_coef (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [mbl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_data,
   output mbl_pkg::coef_type                   coef
);

   mbl_pkg::coef_type coef_ff;
   mbl_pkg::coef_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_write) begin
         case (csr_index)
            mbl_pkg::CSR_GAIN_B:      coef_in.gain_b      = $signed(csr_data);
            mbl_pkg::CSR_FEEDBACK_A1: coef_in.feedback_a1 = $signed(csr_data);
            mbl_pkg::CSR_FEEDBACK_A2: coef_in.feedback_a2 = $signed(csr_data);
            default:                  coef_in             = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.gain_b      <= mbl_pkg::RESET_GAIN_B;
         coef_ff.feedback_a1 <= mbl_pkg::RESET_FEEDBACK_A1;
         coef_ff.feedback_a2 <= mbl_pkg::RESET_FEEDBACK_A2;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== rtl/mbl_lane.sv =====
// One channel of the biquad: history registers and the combinational section arithmetic.
// Depends on mbl_pkg for widths and coef_type.
`timescale 1ns / 1ps

module mbl_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  mbl_pkg::coef_type                    coef,
   input  logic signed [mbl_pkg::SAMPLE_W-1:0]  sample,
   output logic signed [mbl_pkg::SAMPLE_W-1:0]  filtered
);

   localparam int SW = mbl_pkg::SAMPLE_W;
   localparam int AW = mbl_pkg::ACC_W;
   localparam int FW = mbl_pkg::FRAC_W;

   logic signed [SW-1:0] x1_ff, x2_ff, y1_ff, y2_ff;

   logic signed [mbl_pkg::SUM_W-1:0]    tap_sum;
   logic signed [SW+mbl_pkg::SUM_W-1:0] prod_b;
   logic signed [2*SW-1:0]              prod_a1;
   logic signed [2*SW-1:0]              prod_a2;
   logic signed [AW-1:0]                acc;
   logic                                in_range;

   // The numerator taps share one gain, so b*(x + 2*x1 + x2) is one product.
   assign tap_sum = {{2{sample[SW-1]}}, sample}
                  + {x1_ff[SW-1], x1_ff, 1'b0}
                  + {{2{x2_ff[SW-1]}}, x2_ff};

   assign prod_b  = coef.gain_b * tap_sum;
   assign prod_a1 = coef.feedback_a1 * y1_ff;
   assign prod_a2 = coef.feedback_a2 * y2_ff;

   // Exact sum plus half an LSB of the output for round to nearest.
   assign acc = AW'(prod_b) - AW'(prod_a1) - AW'(prod_a2)
              + (AW'(1) <<< (FW - 1));

   // The shifted value fits in 32 bits when the bits above it all match the sign.
   assign in_range = (acc[AW-1:FW+SW-1] == '0) || (acc[AW-1:FW+SW-1] == '1);

   always_comb begin
      if (in_range) begin
         filtered = acc[FW+SW-1:FW];
      end else if (acc[AW-1]) begin
         filtered = {1'b1, {(SW-1){1'b0}}};
      end else begin
         filtered = {1'b0, {(SW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (advance) begin
         x1_ff <= sample;
         x2_ff <= x1_ff;
         y1_ff <= filtered;
         y2_ff <= y1_ff;
      end
   end

endmodule

// ===== rtl/multichannel_biquad_lowpass.sv =====
// Top level of the nine-channel biquad low-pass filter; depends on mbl_pkg, mbl_coef, mbl_lane.
// A word accepted into the input register is filtered as it moves into the result register.
// Throughput: one word per cycle while rsp_stall is low; each lane's y1 loop has one register.
// While a finished word waits to be taken, the input register still accepts one more word.
// Reset is synchronous and active high: it empties both registers, clears all channel history
// and loads the default coefficients.
`timescale 1ns / 1ps

module multichannel_biquad_lowpass (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mbl_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mbl_pkg::rsp_word_type            rsp_word,
   input  logic                             csr_write,
   input  logic [mbl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_data
);

   localparam int SW = mbl_pkg::SAMPLE_W;

   // Input register: the accepted word waits here until the result register can take
   // its filtered counterpart.
   logic                  in_valid_ff, in_valid_in;
   mbl_pkg::req_word_type in_word_ff;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   mbl_pkg::rsp_word_type out_word_ff;
   mbl_pkg::rsp_word_type out_word_in;

   mbl_pkg::coef_type     coef;

   logic signed [SW-1:0]  lane_x [mbl_pkg::LANES];
   logic signed [SW-1:0]  lane_y [mbl_pkg::LANES];

   logic                  advance;
   logic                  req_take;

   // A word moves forward when the result register is empty or is being taken in this cycle.
   // Moving is also the moment the channel histories step.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   mbl_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   // Unpack the sample slots so that the lanes can be generated by index.
   assign lane_x[0] = in_word_ff.sample_0;
   assign lane_x[1] = in_word_ff.sample_1;
   assign lane_x[2] = in_word_ff.sample_2;
   assign lane_x[3] = in_word_ff.sample_3;
   assign lane_x[4] = in_word_ff.sample_4;
   assign lane_x[5] = in_word_ff.sample_5;
   assign lane_x[6] = in_word_ff.sample_6;
   assign lane_x[7] = in_word_ff.sample_7;
   assign lane_x[8] = in_word_ff.sample_8;

   // Every active channel has its own section; slots beyond the channel count read zero and
   // keep no state.
   for (genvar i = 0; i < mbl_pkg::LANES; i++) begin : g_lane
      if (i < mbl_pkg::CHANNELS) begin : g_active
         mbl_lane u_lane (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .coef     (coef),
            .sample   (lane_x[i]),
            .filtered (lane_y[i])
         );
      end else begin : g_idle
         assign lane_y[i] = '0;
      end
   end

   always_comb begin
      out_word_in.filtered_0 = lane_y[0];
      out_word_in.filtered_1 = lane_y[1];
      out_word_in.filtered_2 = lane_y[2];
      out_word_in.filtered_3 = lane_y[3];
      out_word_in.filtered_4 = lane_y[4];
      out_word_in.filtered_5 = lane_y[5];
      out_word_in.filtered_6 = lane_y[6];
      out_word_in.filtered_7 = lane_y[7];
      out_word_in.filtered_8 = lane_y[8];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

`ifndef SYNTHESIS
   // A word that moves forward is on the result channel in the next cycle.
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("filtered word missing after advance");

   // An accepted word occupies the input register in the next cycle.
   a_take_holds: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted word lost from input register");

   // An empty input register never refuses a word.
   a_empty_open: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("stall raised with empty input register");

   // A waiting result that is not taken blocks the input register from moving.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !advance)
      else $error("result register overwritten while stalled");
`endif

endmodule
